/* rtl/core/lfu_pkg.sv */
`default_nettype none

package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 32;
    localparam int STAMP_W = 48;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CNT_W-1:0] COUNT_ONE = 32'd1;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // one entry of the table memory
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [CNT_W-1:0]   count;
        logic [STAMP_W-1:0] stamp;
    } row_t;

    typedef struct packed {
        logic match;
        logic free;
        logic victim;
    } scan_flags_t;

endpackage

`default_nettype wire

/* rtl/core/lfu_if.sv */
`default_nettype none

interface lfu_req_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_value;

    modport source (output valid, output func, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input func, input lookup_key, input write_value,
                    output ready);
endinterface

interface lfu_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

interface lfu_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] capacity_in_use;

    modport source (output valid, output capacity_in_use, input ready);
    modport sink   (input valid, input capacity_in_use, output ready);
endinterface

`default_nettype wire

/* rtl/core/lfu_mem.sv */
`default_nettype none

module lfu_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire lfu_pkg::row_t wdata,
    input  wire logic [AW-1:0] raddr,
    output lfu_pkg::row_t      rdata
);

    lfu_pkg::row_t mem [DEPTH];
    lfu_pkg::row_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/lfu_scan.sv */
`default_nettype none

module lfu_scan #(
    parameter int AW = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            clear,
    input  wire logic            probe,
    input  wire logic [AW-1:0]   idx,
    input  wire logic            ent_valid,
    input  wire lfu_pkg::row_t   row,
    input  wire logic [31:0]     key,
    output lfu_pkg::scan_flags_t flags,
    output logic [AW-1:0]        match_idx,
    output logic [AW-1:0]        free_idx,
    output logic [AW-1:0]        vic_idx,
    output lfu_pkg::row_t        match_row,
    output logic [31:0]          vic_key
);

    lfu_pkg::scan_flags_t flags_reg;
    lfu_pkg::scan_flags_t flags_next;
    logic [AW-1:0]        match_idx_reg;
    logic [AW-1:0]        free_idx_reg;
    logic [AW-1:0]        vic_idx_reg;
    lfu_pkg::row_t        match_row_reg;
    logic [31:0]          vic_key_reg;
    logic [31:0]          vic_cnt_reg;
    logic [47:0]          vic_stamp_reg;

    logic take_match;
    logic take_free;
    logic take_vic;

    always_comb
    begin
        take_match = probe && ent_valid && !flags_reg.match && (row.key == key);
        take_free  = probe && !ent_valid && !flags_reg.free;
        // lowest count wins, ties go to the older stamp
        take_vic   = probe && ent_valid &&
                     (!flags_reg.victim || (row.count < vic_cnt_reg) ||
                      ((row.count == vic_cnt_reg) && (row.stamp < vic_stamp_reg)));
        flags_next        = flags_reg;
        flags_next.match  = flags_reg.match  || take_match;
        flags_next.free   = flags_reg.free   || take_free;
        flags_next.victim = flags_reg.victim || take_vic;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (clear)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_match)
        begin
            match_idx_reg <= idx;
            match_row_reg <= row;
        end
        if (take_free)
        begin
            free_idx_reg <= idx;
        end
        if (take_vic)
        begin
            vic_idx_reg   <= idx;
            vic_key_reg   <= row.key;
            vic_cnt_reg   <= row.count;
            vic_stamp_reg <= row.stamp;
        end
    end

    assign flags     = flags_reg;
    assign match_idx = match_idx_reg;
    assign free_idx  = free_idx_reg;
    assign vic_idx   = vic_idx_reg;
    assign match_row = match_row_reg;
    assign vic_key   = vic_key_reg;

endmodule

`default_nettype wire

/* rtl/core/lfu_cache_table.sv */
// one item is in work at a time: the scan reads every entry through the single read port
// of the entry memory (one entry per cycle), and a new item is taken only after write-back;
// when capacity_in_use is zero the scan is skipped and the item goes straight to write-back
// reset: valid bits, occupancy and stamp clock clear at once, capacity_in_use goes to 16;
// the entry memory itself is not cleared and is only read through a set valid bit
`default_nettype none

module lfu_cache_table #(
    parameter int CAPACITY = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lfu_req_if.sink   req,
    lfu_rsp_if.source rsp,
    lfu_cfg_if.sink   cfg
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OW = $clog2(CAPACITY + 1);
    localparam int CW = (OW > lfu_pkg::CFG_W) ? OW : lfu_pkg::CFG_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_WB    = 2'd3;

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic [lfu_pkg::CFG_W-1:0] cap_cfg_reg;
    logic [OW-1:0]             eff_cap_reg;
    logic                      bypass_reg;
    logic                      func_reg;
    logic [31:0]               key_reg;
    logic [31:0]               val_reg;
    logic [AW-1:0]             rd_idx_reg;
    logic                      cmp_vld_reg;
    logic [AW-1:0]             cmp_idx_reg;
    logic [CAPACITY-1:0]       valid_reg;
    logic [OW-1:0]             occ_reg;
    logic [47:0]               clock_reg;
    logic                      rsp_valid_reg;
    logic                      hit_reg;
    logic [31:0]               rval_reg;
    logic                      evict_reg;
    logic [31:0]               ekey_reg;

    logic [CW-1:0]        cap_ext;
    logic [CW-1:0]        cap_sat;
    logic                 req_fire;
    logic                 rsp_free;
    logic                 wb_go;
    logic                 hit_any;
    logic                 ins_free;
    logic                 ins_vic;
    logic                 mem_we;
    logic [AW-1:0]        waddr;
    lfu_pkg::row_t        wdata;
    lfu_pkg::row_t        rdata;
    logic [47:0]          stamp_next;
    lfu_pkg::scan_flags_t flags;
    logic [AW-1:0]        match_idx;
    logic [AW-1:0]        free_idx;
    logic [AW-1:0]        vic_idx;
    lfu_pkg::row_t        match_row;
    logic [31:0]          vic_key;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign wb_go     = (state_reg == ST_WB) && rsp_free;

    assign cap_ext = CW'(cap_cfg_reg);
    assign cap_sat = (cap_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg <= lfu_pkg::CAP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            cap_cfg_reg <= cfg.capacity_in_use;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (cap_cfg_reg == '0) ? ST_WB : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_idx_reg == AW'(CAPACITY - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            bypass_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == ST_SCAN);
            if (req_fire)
            begin
                rd_idx_reg <= '0;
                bypass_reg <= (cap_cfg_reg == '0);
            end
            else if (state_reg == ST_SCAN)
            begin
                rd_idx_reg <= rd_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= rd_idx_reg;
        if (req_fire)
        begin
            func_reg    <= req.func;
            key_reg     <= req.lookup_key;
            val_reg     <= req.write_value;
            eff_cap_reg <= OW'(cap_sat);
        end
    end

    lfu_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    lfu_scan #(
        .AW (AW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (req_fire),
        .probe     (cmp_vld_reg),
        .idx       (cmp_idx_reg),
        .ent_valid (valid_reg[cmp_idx_reg]),
        .row       (rdata),
        .key       (key_reg),
        .flags     (flags),
        .match_idx (match_idx),
        .free_idx  (free_idx),
        .vic_idx   (vic_idx),
        .match_row (match_row),
        .vic_key   (vic_key)
    );

    // write-back decision once the scan is complete
    always_comb
    begin
        stamp_next = clock_reg + 48'd1;
        hit_any    = !bypass_reg && flags.match;
        ins_free   = !bypass_reg && (func_reg == lfu_pkg::FUNC_PUT) && !flags.match &&
                     (occ_reg < eff_cap_reg) && flags.free;
        ins_vic    = !bypass_reg && (func_reg == lfu_pkg::FUNC_PUT) && !flags.match &&
                     !ins_free && flags.victim;
        mem_we     = wb_go && (hit_any || ins_free || ins_vic);
        waddr      = hit_any ? match_idx : (ins_free ? free_idx : vic_idx);
        if (hit_any)
        begin
            wdata       = match_row;
            wdata.count = (match_row.count == lfu_pkg::COUNT_MAX) ?
                          lfu_pkg::COUNT_MAX : match_row.count + lfu_pkg::COUNT_ONE;
            wdata.stamp = stamp_next;
            if (func_reg == lfu_pkg::FUNC_PUT)
            begin
                wdata.data = val_reg;
            end
        end
        else
        begin
            wdata.key   = key_reg;
            wdata.data  = val_reg;
            wdata.count = lfu_pkg::COUNT_ONE;
            wdata.stamp = stamp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            clock_reg <= '0;
        end
        else if (mem_we)
        begin
            clock_reg <= stamp_next;
            if (ins_free || ins_vic)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (ins_free)
            begin
                occ_reg <= occ_reg + OW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (wb_go)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_go)
        begin
            hit_reg   <= hit_any;
            rval_reg  <= (hit_any && (func_reg == lfu_pkg::FUNC_GET)) ? match_row.data : '0;
            evict_reg <= ins_vic;
            ekey_reg  <= ins_vic ? vic_key : '0;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.read_value  = rval_reg;
    assign rsp.evicted     = evict_reg;
    assign rsp.evicted_key = ekey_reg;

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy does not match the valid bits");

    a_write_in_wb: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_WB))
        else $error("table write outside write-back");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ST_SCAN || state_reg == ST_WB))
        else $error("accepted item did not start");

    a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.evicted) |-> !rsp.hit)
        else $error("eviction reported together with a hit");

endmodule

`default_nettype wire

/* sim/lfu_cache_table_tb.sv */
`default_nettype none

module lfu_cache_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int LATENCY = SLOTS + 3;
    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_GAP = 16;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam logic [lfu_pkg::CFG_W-1:0] CAP_OFF = '0;
    localparam logic [lfu_pkg::CFG_W-1:0] CAP_TOP = '1;
    localparam logic [lfu_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [lfu_pkg::KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam logic [lfu_pkg::KEY_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic                       hit;
        logic [lfu_pkg::DATA_W-1:0] read_value;
        logic                       evicted;
        logic [lfu_pkg::KEY_W-1:0]  evicted_key;
    } access_result_t;

    logic clk = 1'b0;
    logic rst_n;

    lfu_req_if req ();
    lfu_rsp_if rsp ();
    lfu_cfg_if cfg ();

    lfu_cache_table #(
        .CAPACITY (SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shadow copy of the table
    logic                        cache_valid [SLOTS] = '{default: 1'b0};
    logic [lfu_pkg::KEY_W-1:0]   cache_key   [SLOTS];
    logic [lfu_pkg::DATA_W-1:0]  cache_data  [SLOTS];
    logic [lfu_pkg::CNT_W-1:0]   cache_count [SLOTS];
    logic [lfu_pkg::STAMP_W-1:0] cache_stamp [SLOTS];
    logic [lfu_pkg::STAMP_W-1:0] cache_clock = '0;
    int                          cache_occupancy = 0;
    logic [lfu_pkg::CFG_W-1:0]   cache_capacity = lfu_pkg::CAP_RESET;

    access_result_t pending_lookups [$];
    int mismatches = 0;
    int quiet_cycles = 0;
    int long_hold_request = 0;
    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;

    function automatic access_result_t predict_access(
        input logic op,
        input logic [lfu_pkg::KEY_W-1:0] key,
        input logic [lfu_pkg::DATA_W-1:0] value);
        access_result_t res;
        int cap;
        int slot;
        int i;
        res = '0;
        cap = (cache_capacity > SLOTS) ? SLOTS : int'(cache_capacity);
        if (cap == 0)
            return res;
        slot = -1;
        for (i = 0; i < SLOTS; i++)
            if (slot < 0 && cache_valid[i] && cache_key[i] == key)
                slot = i;
        if (slot >= 0)
        begin
            res.hit = 1'b1;
            if (op == lfu_pkg::FUNC_GET)
                res.read_value = cache_data[slot];
            else
                cache_data[slot] = value;
            if (cache_count[slot] != lfu_pkg::COUNT_MAX)
                cache_count[slot] = cache_count[slot] + 1'b1;
            cache_clock = cache_clock + 1'b1;
            cache_stamp[slot] = cache_clock;
            return res;
        end
        if (op == lfu_pkg::FUNC_GET)
            return res;
        // insert: a free slot while under capacity, otherwise replace the victim
        if (cache_occupancy < cap)
            for (i = 0; i < SLOTS; i++)
                if (slot < 0 && !cache_valid[i])
                    slot = i;
        if (slot < 0)
        begin
            for (i = 0; i < SLOTS; i++)
                if (cache_valid[i] && (slot < 0 || cache_count[i] < cache_count[slot] ||
                    (cache_count[i] == cache_count[slot] &&
                     cache_stamp[i] < cache_stamp[slot])))
                    slot = i;
            res.evicted = 1'b1;
            res.evicted_key = cache_key[slot];
            cache_occupancy--;
        end
        cache_valid[slot] = 1'b1;
        cache_key[slot] = key;
        cache_data[slot] = value;
        cache_count[slot] = lfu_pkg::COUNT_ONE;
        cache_clock = cache_clock + 1'b1;
        cache_stamp[slot] = cache_clock;
        cache_occupancy++;
        return res;
    endfunction

    function automatic void report_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        access_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual hit %b read %h",
                         $time, rsp.hit, rsp.read_value);
                $display("%0t: actual evicted %b key %h",
                         $time, rsp.evicted, rsp.evicted_key);
                mismatches++;
            end
            else
            begin
                want = pending_lookups.pop_front();
                report_field("hit", want.hit, rsp.hit);
                report_field("read_value", want.read_value, rsp.read_value);
                report_field("evicted", want.evicted, rsp.evicted);
                report_field("evicted_key", want.evicted_key, rsp.evicted_key);
            end
        end
    end

    // result side: random stalls per item, plus one long hold-off on request
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_request > 0)
            begin
                stall_left = long_hold_request;
                long_hold_request = 0;
            end
            else if (rsp.valid && rsp.ready)
                stall_left = recv_idle_en ? $urandom_range(0, MAX_GAP) : 0;
            else if (stall_left > 0)
                stall_left--;
            rsp.ready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // valid stays high when the next item follows without a gap
    task automatic send_access(input logic op, input logic [lfu_pkg::KEY_W-1:0] key,
                               input logic [lfu_pkg::DATA_W-1:0] value);
        int gap;
        gap = send_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.func <= op;
        req.lookup_key <= key;
        req.write_value <= value;
        do
            @(posedge clk);
        while (!req.ready);
        pending_lookups.push_back(predict_access(op, key, value));
    endtask

    task automatic drain_block();
        req.valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [lfu_pkg::CFG_W-1:0] cap);
        drain_block();
        cfg.valid <= 1'b1;
        cfg.capacity_in_use <= cap;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        cache_capacity = cap;
    endtask

    task automatic test_basic_access();
        send_access(lfu_pkg::FUNC_GET, KEY_MAX, $urandom);
        send_access(lfu_pkg::FUNC_PUT, KEY_MIN, KEY_MAX);
        send_access(lfu_pkg::FUNC_PUT, KEY_MAX, KEY_MIN);
        send_access(lfu_pkg::FUNC_PUT, '0, ALL_ONES);
        send_access(lfu_pkg::FUNC_PUT, ALL_ONES, '0);
        send_access(lfu_pkg::FUNC_GET, KEY_MIN, ALL_ONES);
        send_access(lfu_pkg::FUNC_PUT, KEY_MAX, 32'h1234_5678);
        send_access(lfu_pkg::FUNC_GET, KEY_MAX, '0);
        send_access(lfu_pkg::FUNC_GET, 32'd1, $urandom);
    endtask

    // capacity below occupancy: each insert replaces the lowest count, oldest first
    task automatic test_victim_choice();
        write_capacity(5'd3);
        send_access(lfu_pkg::FUNC_PUT, 32'd5, 32'd50);
        send_access(lfu_pkg::FUNC_GET, ALL_ONES, '0);
        send_access(lfu_pkg::FUNC_PUT, 32'd6, 32'd60);
        send_access(lfu_pkg::FUNC_PUT, 32'd7, 32'd70);
        send_access(lfu_pkg::FUNC_GET, 32'd7, '0);
        send_access(lfu_pkg::FUNC_GET, 32'd7, '0);
        send_access(lfu_pkg::FUNC_PUT, 32'd8, 32'd80);
        send_access(lfu_pkg::FUNC_GET, KEY_MIN, '0);
    endtask

    task automatic test_capacity_extremes();
        // disabled: present keys miss and puts leave the table alone
        write_capacity(CAP_OFF);
        send_access(lfu_pkg::FUNC_GET, 32'd7, '0);
        send_access(lfu_pkg::FUNC_PUT, 32'd9, 32'd90);
        send_access(lfu_pkg::FUNC_GET, 32'd9, '0);
        // above the table size the capacity saturates
        write_capacity(CAP_TOP);
        send_access(lfu_pkg::FUNC_GET, 32'd7, '0);
        send_access(lfu_pkg::FUNC_PUT, 32'd10, 32'd100);
        send_access(lfu_pkg::FUNC_GET, 32'd10, '0);
    endtask

    task automatic test_backpressure();
        int n;
        drain_block();
        send_idle_en = 1'b0;
        long_hold_request = HOLD_OFF_CYCLES;
        for (n = 0; n < 24; n++)
            send_access($urandom_range(0, 1) ? lfu_pkg::FUNC_PUT : lfu_pkg::FUNC_GET,
                        32'd1 + $urandom_range(0, 19), $urandom);
        send_idle_en = 1'b1;
        drain_block();
    endtask

    task automatic test_random_traffic();
        logic [lfu_pkg::CFG_W-1:0] phase_caps [10];
        logic [lfu_pkg::KEY_W-1:0] key_pool [32];
        logic [lfu_pkg::KEY_W-1:0] key;
        int p;
        int n;
        int item_count;
        int pool_size;
        int mode;
        phase_caps = '{5'd16, 5'd1, 5'd5, CAP_OFF, CAP_TOP, 5'd8, 5'd2, 5'd17, 5'd12, 5'd16};
        for (p = 0; p < 10; p++)
        begin
            write_capacity(phase_caps[p]);
            pool_size = ((phase_caps[p] > SLOTS) ? SLOTS : int'(phase_caps[p])) +
                        $urandom_range(1, 8);
            for (n = 0; n < 32; n++)
                key_pool[n] = $urandom;
            key_pool[0] = KEY_MIN;
            key_pool[1] = KEY_MAX;
            item_count = (phase_caps[p] == CAP_OFF) ? 40 : 118;
            for (n = 0; n < item_count; n++)
            begin
                if (n % 40 == 0)
                begin
                    mode = $urandom_range(0, 3);
                    send_idle_en = mode[0];
                    recv_idle_en = mode[1];
                end
                // mostly keys from a small pool so that hits and evictions recur
                if ($urandom_range(0, 4) == 0)
                    key = $urandom;
                else
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                send_access($urandom_range(0, 1) ? lfu_pkg::FUNC_PUT : lfu_pkg::FUNC_GET,
                            key, $urandom);
            end
        end
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.func <= lfu_pkg::FUNC_GET;
        req.lookup_key <= '0;
        req.write_value <= '0;
        cfg.valid <= 1'b0;
        cfg.capacity_in_use <= lfu_pkg::CAP_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_access();
        test_victim_choice();
        test_capacity_extremes();
        test_backpressure();
        test_random_traffic();
        drain_block();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
